[rtl/pdt_pkg.sv]
`default_nettype none
package pdt_pkg;

  localparam int unsigned KEY_W    = 256;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned EP_W     = 48;
  localparam int unsigned TIME_W   = 30;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned AGE_W    = TIME_W + 1;

  localparam logic [TIME_W-1:0] EXPIRY_RESET = TIME_W'(4000000);
  localparam logic [AGE_W-1:0]  TIME_WRAP    = AGE_W'(1000000000);

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } pdt_state_t;

endpackage
`default_nettype wire

[rtl/pdt_channels.sv]
`default_nettype none
interface pdt_in_if;
  import pdt_pkg::*;
  logic                valid;
  logic                ready;
  logic                operation;
  logic [WORD_W-1:0]   my_key_0;
  logic [WORD_W-1:0]   my_key_1;
  logic [WORD_W-1:0]   my_key_2;
  logic [WORD_W-1:0]   my_key_3;
  logic [WORD_W-1:0]   remote_key_0;
  logic [WORD_W-1:0]   remote_key_1;
  logic [WORD_W-1:0]   remote_key_2;
  logic [WORD_W-1:0]   remote_key_3;
  logic [SLOT_W-1:0]   slot_index;
  logic [EP_W-1:0]     source_endpoint;
  logic [TIME_W-1:0]   now_us;

  modport source (output valid, operation, my_key_0, my_key_1, my_key_2, my_key_3,
                  remote_key_0, remote_key_1, remote_key_2, remote_key_3,
                  slot_index, source_endpoint, now_us, input ready);
  modport sink (input valid, operation, my_key_0, my_key_1, my_key_2, my_key_3,
                remote_key_0, remote_key_1, remote_key_2, remote_key_3,
                slot_index, source_endpoint, now_us, output ready);
endinterface

interface pdt_out_if;
  import pdt_pkg::*;
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   answer_key_0;
  logic [WORD_W-1:0]   answer_key_1;
  logic [WORD_W-1:0]   answer_key_2;
  logic [WORD_W-1:0]   answer_key_3;
  logic [EP_W-1:0]     masked_endpoint;
  logic [EP_W-1:0]     reply_destination;

  modport source (output valid, answer_key_0, answer_key_1, answer_key_2, answer_key_3,
                  masked_endpoint, reply_destination, input ready);
  modport sink (input valid, answer_key_0, answer_key_1, answer_key_2, answer_key_3,
                masked_endpoint, reply_destination, output ready);
endinterface

interface pdt_cfg_if;
  import pdt_pkg::*;
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/pdt_ram.sv]
`default_nettype none
module pdt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic                                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[rtl/peer_discovery_table.sv]
// Peer discovery table.
// Input channel in_ch takes a discovery request or an expiry tick. Each
// tick, and each request with a slot index below ENDPOINTS, starts one scan
// over all PEERS entries held in synchronous memories, one entry per cycle
// through a read, compare and write-back stage. The block takes one
// transaction at a time: in_ch.ready stays low from the accepting edge until
// the scan is over. A request with a slot index of ENDPOINTS or more is
// accepted and dropped without a scan.
// A request whose sought peer has the slot filled yields one result
// transaction on out_ch at the end of the scan; other transactions yield none.
// The result sits in an output register, so a new transaction is accepted
// while it waits; if the receiver stalls and the next scan also ends with an
// answer, that scan holds in its last step until the register is free.
// cfg_ch writes the expiry time and is always ready; the user must write
// it only while the block is idle; the block does not enforce this. After
// reset a sweep of the entry state memory clears it, with in_ch.ready low.
`default_nettype none
module peer_discovery_table #(
  parameter int unsigned PEERS     = 1024,
  parameter int unsigned ENDPOINTS = 5
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pdt_in_if.sink     in_ch,
  pdt_out_if.source  out_ch,
  pdt_cfg_if.sink    cfg_ch
);
  import pdt_pkg::*;

  localparam int unsigned AW   = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int unsigned SW   = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
  localparam int unsigned MW   = 1 + ENDPOINTS + TIME_W;
  localparam int unsigned ROWW = EP_W * ENDPOINTS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PEERS - 1);

  pdt_state_t state_r, state_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic               issue_on_r, issue_on_nxt;
  logic               s1_vld_r;
  logic [AW-1:0]      s1_addr_r;
  logic               op_r, op_nxt;
  logic [KEY_W-1:0]   my_key_r, my_key_nxt;
  logic [KEY_W-1:0]   rem_key_r, rem_key_nxt;
  logic [SW-1:0]      slot_r, slot_nxt;
  logic [EP_W-1:0]    src_r, src_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [TIME_W-1:0]  expiry_r;
  logic               have_free_r, have_free_nxt;
  logic [AW-1:0]      free_at_r, free_at_nxt;
  logic               updated_r, updated_nxt;
  logic               answered_r, answered_nxt;
  logic [EP_W-1:0]    ans_ep_r, ans_ep_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [KEY_W-1:0]   out_key_r, out_key_nxt;
  logic [EP_W-1:0]    out_mask_r, out_mask_nxt;
  logic [EP_W-1:0]    out_dst_r, out_dst_nxt;

  logic               rd_en;
  logic [MW-1:0]      meta_rd, meta_wd;
  logic               meta_we;
  logic [AW-1:0]      meta_wa;
  logic [KEY_W-1:0]   key_rd;
  logic               key_we;
  logic [ROWW-1:0]    row_rd, row_wd, row_upd;
  logic               row_we;
  logic [AW-1:0]      row_wa;

  logic                 e_used, my_match, rem_match, expired, hit;
  logic [ENDPOINTS-1:0] e_filled, filled_up, slot_bit;
  logic [TIME_W-1:0]    seen_up;
  logic signed [AGE_W-1:0] diff, age;
  logic                 in_acc, out_free;

  pdt_ram #(.WIDTH(MW), .DEPTH(PEERS)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
    .re(rd_en), .raddr(cnt_r), .rdata(meta_rd)
  );

  pdt_ram #(.WIDTH(KEY_W), .DEPTH(PEERS)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(free_at_r), .wdata(my_key_r),
    .re(rd_en), .raddr(cnt_r), .rdata(key_rd)
  );

  pdt_ram #(.WIDTH(ROWW), .DEPTH(PEERS)) u_ep_ram (
    .clk(clk), .we(row_we), .waddr(row_wa), .wdata(row_wd),
    .re(rd_en), .raddr(cnt_r), .rdata(row_rd)
  );

  assign e_used   = meta_rd[MW-1];
  assign e_filled = meta_rd[MW-2 -: ENDPOINTS];
  assign slot_bit = ENDPOINTS'(1) << slot_r;

  assign my_match  = (op_r == OP_REQUEST) && e_used && (key_rd == my_key_r);
  assign rem_match = (op_r == OP_REQUEST) && e_used && (key_rd == rem_key_r);
  assign filled_up = my_match ? (e_filled | slot_bit) : e_filled;
  assign seen_up   = my_match ? now_r : meta_rd[TIME_W-1:0];

  assign diff    = $signed({1'b0, now_r}) - $signed({1'b0, seen_up});
  assign age     = diff[AGE_W-1] ? (diff + $signed(TIME_WRAP)) : diff;
  assign expired = !age[AGE_W-1] && (age[TIME_W-1:0] >= expiry_r);

  assign hit = s1_vld_r && rem_match && !answered_r && filled_up[slot_r];

  for (genvar i = 0; i < ENDPOINTS; i++) begin : g_row
    assign row_upd[i*EP_W +: EP_W] =
      (slot_r == SW'(i)) ? src_r : row_rd[i*EP_W +: EP_W];
  end

  assign rd_en    = (state_r == ST_SCAN) && issue_on_r;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_vld_r || out_ch.ready;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid             = out_vld_r;
  assign out_ch.answer_key_0      = out_key_r[255:192];
  assign out_ch.answer_key_1      = out_key_r[191:128];
  assign out_ch.answer_key_2      = out_key_r[127:64];
  assign out_ch.answer_key_3      = out_key_r[63:0];
  assign out_ch.masked_endpoint   = out_mask_r;
  assign out_ch.reply_destination = out_dst_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    issue_on_nxt  = issue_on_r;
    op_nxt        = op_r;
    my_key_nxt    = my_key_r;
    rem_key_nxt   = rem_key_r;
    slot_nxt      = slot_r;
    src_nxt       = src_r;
    now_nxt       = now_r;
    have_free_nxt = have_free_r;
    free_at_nxt   = free_at_r;
    updated_nxt   = updated_r;
    answered_nxt  = answered_r;
    ans_ep_nxt    = ans_ep_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    out_key_nxt   = out_key_r;
    out_mask_nxt  = out_mask_r;
    out_dst_nxt   = out_dst_r;
    meta_we       = 1'b0;
    meta_wa       = s1_addr_r;
    meta_wd       = {!expired, (expired ? {ENDPOINTS{1'b0}} : filled_up), seen_up};
    key_we        = 1'b0;
    row_we        = 1'b0;
    row_wa        = s1_addr_r;
    row_wd        = row_upd;

    case (state_r)
      ST_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = cnt_r;
        meta_wd = '0;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_ch.operation;
          my_key_nxt    = {in_ch.my_key_0, in_ch.my_key_1, in_ch.my_key_2, in_ch.my_key_3};
          rem_key_nxt   = {in_ch.remote_key_0, in_ch.remote_key_1,
                           in_ch.remote_key_2, in_ch.remote_key_3};
          slot_nxt      = SW'(in_ch.slot_index);
          src_nxt       = in_ch.source_endpoint;
          now_nxt       = in_ch.now_us;
          have_free_nxt = 1'b0;
          updated_nxt   = 1'b0;
          answered_nxt  = 1'b0;
          cnt_nxt       = '0;
          issue_on_nxt  = 1'b1;
          if ((in_ch.operation == OP_TICK) ||
              (32'(in_ch.slot_index) < ENDPOINTS)) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          cnt_nxt = cnt_r + AW'(1);
          if (cnt_r == LAST_ADDR) begin
            issue_on_nxt = 1'b0;
          end
        end
        if (s1_vld_r) begin
          if (!e_used) begin
            have_free_nxt = 1'b1;
            free_at_nxt   = s1_addr_r;
          end else begin
            meta_we = 1'b1;
          end
          if (my_match) begin
            row_we      = 1'b1;
            updated_nxt = 1'b1;
          end
          if (hit) begin
            answered_nxt = 1'b1;
            ans_ep_nxt   = (my_match ? src_r : row_rd[slot_r*EP_W +: EP_W])
                           ^ my_key_r[KEY_W-1 -: EP_W];
          end
          if (s1_addr_r == LAST_ADDR) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if ((op_r == OP_REQUEST) && !updated_r && have_free_r) begin
          key_we  = 1'b1;
          meta_we = 1'b1;
          meta_wa = free_at_r;
          meta_wd = {1'b1, slot_bit, now_r};
          row_we  = 1'b1;
          row_wa  = free_at_r;
          row_wd  = {ENDPOINTS{src_r}};
        end
        if (!answered_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_key_nxt  = rem_key_r;
          out_mask_nxt = ans_ep_r;
          out_dst_nxt  = src_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      cnt_r      <= '0;
      issue_on_r <= 1'b0;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      expiry_r   <= EXPIRY_RESET;
      answered_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      issue_on_r <= issue_on_nxt;
      s1_vld_r   <= rd_en;
      out_vld_r  <= out_vld_nxt;
      answered_r <= answered_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        expiry_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r   <= cnt_r;
    op_r        <= op_nxt;
    my_key_r    <= my_key_nxt;
    rem_key_r   <= rem_key_nxt;
    slot_r      <= slot_nxt;
    src_r       <= src_nxt;
    now_r       <= now_nxt;
    have_free_r <= have_free_nxt;
    free_at_r   <= free_at_nxt;
    updated_r   <= updated_nxt;
    ans_ep_r    <= ans_ep_nxt;
    out_key_r   <= out_key_nxt;
    out_mask_r  <= out_mask_nxt;
    out_dst_r   <= out_dst_nxt;
  end

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r) == ST_FINISH)
    else $error("Result appeared outside the end of a scan.");

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !s1_vld_r && !rd_en)
    else $error("Input ready while a scan is in flight.");

  a_key_write_finish: assert property (@(posedge clk) disable iff (!rst_n)
    key_we |-> state_r == ST_FINISH && !updated_r && have_free_r)
    else $error("Key memory written outside an insert.");

  a_answer_once: assert property (@(posedge clk) disable iff (!rst_n)
    answered_r && state_r == ST_SCAN |=> answered_r)
    else $error("Answer flag dropped during a scan.");

endmodule
`default_nettype wire
